// ===== rtl/wsfb_pkg.sv =====
// shared types, constants and header byte function of the websocket frame builder
package wsfb_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int PAYLOAD_LEN_W   = 24;
  localparam int MAX_PAYLOAD_W   = 24;
  localparam int CAPACITY_W      = 25;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 25;
  localparam int IN_TDATA_W      = 72;
  localparam int OUT_TDATA_W     = 8;
  localparam int STATUS_W        = 2;

  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 24'(4 * 1024 * 1024);
  localparam logic [CAPACITY_W-1:0]    CAPACITY_RST    = 25'd16777229;
  localparam logic [CAPACITY_W-1:0]    MIN_CAPACITY    = 25'd6;

  localparam logic [PAYLOAD_LEN_W-1:0] LEN_7BIT_MAX  = 24'd125;
  localparam logic [PAYLOAD_LEN_W-1:0] LEN_16BIT_MAX = 24'd65535;

  localparam logic [7:0] FIN_BIT   = 8'h80;
  localparam logic [7:0] MASK_BIT  = 8'h80;
  localparam logic [7:0] LEN_CODE16 = 8'd126;
  localparam logic [7:0] LEN_CODE64 = 8'd127;

  // index of the final header byte for each length form
  localparam logic [3:0] HDR_LAST_SHORT = 4'd5;
  localparam logic [3:0] HDR_LAST_MID   = 4'd7;
  localparam logic [3:0] HDR_LAST_LONG  = 4'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SIZE    = 2'd1,
    ST_NOFRAME = 2'd2
  } status_e;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } operation_e;

  typedef struct packed {
    operation_e                operation;
    logic [3:0]                opcode;
    logic [PAYLOAD_LEN_W-1:0]  payload_length;
    logic [31:0]               mask_word;
    logic [7:0]                data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
  } res_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_t;

  function automatic logic [7:0] hdr_byte(logic [3:0] last_idx, logic [3:0] idx,
                                          logic [3:0] opcode, logic [63:0] len,
                                          logic [31:0] key);
    logic [3:0] key_base;
    logic [3:0] len_base;
    logic [3:0] kk;
    logic [3:0] sh;
    logic [7:0] b;
    key_base = last_idx - 4'd3;
    len_base = (last_idx == HDR_LAST_MID) ? 4'd3 : 4'd9;
    kk = idx - key_base;
    sh = len_base - idx;
    if (idx == 4'd0) begin
      b = FIN_BIT | {4'd0, opcode};
    end else if (idx >= key_base) begin
      b = 8'(key >> {~kk[1:0], 3'b000});
    end else if (idx == 4'd1) begin
      if (last_idx == HDR_LAST_SHORT) begin
        b = MASK_BIT | {1'b0, len[6:0]};
      end else if (last_idx == HDR_LAST_MID) begin
        b = MASK_BIT | LEN_CODE16;
      end else begin
        b = MASK_BIT | LEN_CODE64;
      end
    end else begin
      b = 8'(len >> {sh[2:0], 3'b000});
    end
    return b;
  endfunction

endpackage

// ===== rtl/wsfb_core.sv =====
// frame state, configuration registers and header sequencer
module wsfb_core #(
  parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wsfb_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wsfb_pkg::item_t item_i,
  output logic            res_valid_o,
  output wsfb_pkg::res_t  res_o,
  input  logic            res_ready_i
);

  localparam int LEN_W = (LENGTH_BITS < wsfb_pkg::PAYLOAD_LEN_W) ? LENGTH_BITS
                                                                 : wsfb_pkg::PAYLOAD_LEN_W;

  logic [wsfb_pkg::MAX_PAYLOAD_W-1:0] maxp_q, maxp_d;
  logic [wsfb_pkg::CAPACITY_W-1:0]    cap_q, cap_d;
  logic                               open_q, open_d;
  logic                               rej_q, rej_d;
  logic [LEN_W-1:0]                   rem_q, rem_d;
  logic [1:0]                         phase_q, phase_d;
  logic [31:0]                        mask_q, mask_d;
  logic                               busy_q, busy_d;
  logic [3:0]                         idx_q, idx_d;
  logic [3:0]                         hlast_q, hlast_d;
  logic [3:0]                         opc_q, opc_d;

  logic                               in_fire;
  logic [LEN_W-1:0]                   len_c;
  logic [wsfb_pkg::PAYLOAD_LEN_W-1:0] len_ext;
  logic [3:0]                         hlast_c;
  logic [wsfb_pkg::CAPACITY_W:0]      frame_sz;
  logic                               reject_c;
  logic [7:0]                         key_byte;

  assign in_ready_o = res_ready_i && !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len_c   = item_i.payload_length[LEN_W-1:0];
  assign len_ext = wsfb_pkg::PAYLOAD_LEN_W'(len_c);

  always_comb begin
    if (len_ext <= wsfb_pkg::LEN_7BIT_MAX) begin
      hlast_c = wsfb_pkg::HDR_LAST_SHORT;
    end else if (len_ext <= wsfb_pkg::LEN_16BIT_MAX) begin
      hlast_c = wsfb_pkg::HDR_LAST_MID;
    end else begin
      hlast_c = wsfb_pkg::HDR_LAST_LONG;
    end
  end

  assign frame_sz = (wsfb_pkg::CAPACITY_W+1)'(hlast_c) + (wsfb_pkg::CAPACITY_W+1)'(1)
                  + (wsfb_pkg::CAPACITY_W+1)'(len_ext);
  assign reject_c = (cap_q < wsfb_pkg::MIN_CAPACITY) || (len_ext > maxp_q)
                  || (frame_sz > (wsfb_pkg::CAPACITY_W+1)'(cap_q));

  assign key_byte = 8'(mask_q >> {~phase_q, 3'b000});

  always_comb begin
    maxp_d  = maxp_q;
    cap_d   = cap_q;
    open_d  = open_q;
    rej_d   = rej_q;
    rem_d   = rem_q;
    phase_d = phase_q;
    mask_d  = mask_q;
    busy_d  = busy_q;
    idx_d   = idx_q;
    hlast_d = hlast_q;
    opc_d   = opc_q;
    res_valid_o     = 1'b0;
    res_o.out_byte  = '0;
    res_o.last      = 1'b0;
    res_o.status    = wsfb_pkg::ST_OK;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        wsfb_pkg::CFG_MAX_PAYLOAD: maxp_d = cfg_i.data[wsfb_pkg::MAX_PAYLOAD_W-1:0];
        wsfb_pkg::CFG_CAPACITY:    cap_d  = cfg_i.data[wsfb_pkg::CAPACITY_W-1:0];
        default: ;
      endcase
    end

    if (busy_q && res_ready_i) begin
      res_valid_o    = 1'b1;
      res_o.out_byte = wsfb_pkg::hdr_byte(hlast_q, idx_q, opc_q, 64'(rem_q), mask_q);
      res_o.last     = (idx_q == hlast_q) && (rem_q == '0);
      idx_d          = idx_q + 4'd1;
      if (idx_q == hlast_q) begin
        busy_d = 1'b0;
      end
    end else if (in_fire) begin
      if (item_i.operation == wsfb_pkg::OP_START) begin
        open_d  = (len_c != '0);
        rem_d   = len_c;
        phase_d = 2'd0;
        mask_d  = item_i.mask_word;
        res_valid_o = 1'b1;
        if (reject_c) begin
          rej_d        = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = wsfb_pkg::ST_SIZE;
        end else begin
          rej_d          = 1'b0;
          busy_d         = 1'b1;
          idx_d          = 4'd1;
          hlast_d        = hlast_c;
          opc_d          = item_i.opcode;
          res_o.out_byte = wsfb_pkg::FIN_BIT | {4'd0, item_i.opcode};
        end
      end else if (!open_q) begin
        res_valid_o  = 1'b1;
        res_o.last   = 1'b1;
        res_o.status = wsfb_pkg::ST_NOFRAME;
      end else begin
        rem_d = rem_q - LEN_W'(1);
        if (rem_q == LEN_W'(1)) begin
          open_d = 1'b0;
          rej_d  = 1'b0;
        end
        if (!rej_q) begin
          res_valid_o    = 1'b1;
          res_o.out_byte = item_i.data_byte ^ key_byte;
          res_o.last     = (rem_q == LEN_W'(1));
          phase_d        = phase_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxp_q  <= wsfb_pkg::MAX_PAYLOAD_RST;
      cap_q   <= wsfb_pkg::CAPACITY_RST;
      open_q  <= 1'b0;
      rej_q   <= 1'b0;
      rem_q   <= '0;
      phase_q <= 2'd0;
      mask_q  <= '0;
      busy_q  <= 1'b0;
      idx_q   <= 4'd0;
      hlast_q <= wsfb_pkg::HDR_LAST_SHORT;
      opc_q   <= 4'd0;
    end else begin
      maxp_q  <= maxp_d;
      cap_q   <= cap_d;
      open_q  <= open_d;
      rej_q   <= rej_d;
      rem_q   <= rem_d;
      phase_q <= phase_d;
      mask_q  <= mask_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      hlast_q <= hlast_d;
      opc_q   <= opc_d;
    end
  end

endmodule

// ===== rtl/wsfb_skid.sv =====
// two-entry result buffer between the core and the output stream
module wsfb_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  wsfb_pkg::res_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output wsfb_pkg::res_t rd_data_o
);

  wsfb_pkg::res_t mem_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_fire;
  logic           rd_fire;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q ^ wr_fire;
    rptr_d = rptr_q ^ rd_fire;
    cnt_d  = cnt_q + {1'b0, wr_fire} - {1'b0, rd_fire};
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/websocket_frame_builder.sv =====
// top level of the masked client websocket frame builder
// A payload item is taken every clock while the header sequencer is idle and the result
// buffer has room; in an open, accepted frame it gives one masked byte, registered in the
// result buffer. A start item that passes the size checks holds the input while the header
// of 6, 8 or 14 bytes (7-bit, 16-bit or 64-bit length form) is sent, one byte at a time by
// the header sequencer after the first; a rejected start gives one error item. Results pass
// through a two-entry buffer, so the input keeps flowing while the buffer has a free entry
// and stalls once both entries are full. Configuration writes are taken every cycle.
module websocket_frame_builder #(
  parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode, payload_length, mask_word, data_byte, zero fill
  input  logic [wsfb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_byte
  output logic [wsfb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast,
  // status
  output logic [wsfb_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wsfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wsfb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  wsfb_pkg::item_t item;
  wsfb_pkg::cfg_t  cfg;
  wsfb_pkg::res_t  core_res;
  wsfb_pkg::res_t  out_res;
  logic            core_valid;
  logic            buf_ready;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  assign item.operation      = wsfb_pkg::operation_e'(s_axis_tuser);
  assign item.opcode         = s_axis_tdata[3:0];
  assign item.payload_length = s_axis_tdata[27:4];
  assign item.mask_word      = s_axis_tdata[59:28];
  assign item.data_byte      = s_axis_tdata[67:60];

  wsfb_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .res_valid_o (core_valid),
    .res_o       (core_res),
    .res_ready_i (buf_ready)
  );

  wsfb_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (core_valid),
    .wr_ready_o (buf_ready),
    .wr_data_i  (core_res),
    .rd_valid_o (m_axis_tvalid),
    .rd_ready_i (m_axis_tready),
    .rd_data_o  (out_res)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.status;

endmodule

// ===== rtl/wsfb_checker.sv =====
// port-level assertions for the websocket frame builder, bound to the top level
module wsfb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [wsfb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic [wsfb_pkg::STATUS_W-1:0]     m_axis_tuser
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // error items are a zero byte that closes the run
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != wsfb_pkg::ST_OK) |->
      m_axis_tlast && (m_axis_tdata == '0))
    else $error("error item not a zero last byte");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == wsfb_pkg::ST_OK) || (m_axis_tuser == wsfb_pkg::ST_SIZE)
      || (m_axis_tuser == wsfb_pkg::ST_NOFRAME))
    else $error("undefined status code");

  // an accepted start item gives a valid output item in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == wsfb_pkg::OP_START) |=> m_axis_tvalid)
    else $error("start item gave no output");

endmodule

bind websocket_frame_builder wsfb_checker u_wsfb_checker (.*);
